// ----- design/pdll_pkg.sv -----
// Shared types and codes for the pooled doubly linked list block.
package pdll_pkg;

  localparam int ACTION_W  = 3;
  localparam int LIST_ID_W = 3;
  localparam int ITEM_W    = 32;
  localparam int STATUS_W  = 2;
  localparam int COUNT_W   = 9;

  localparam logic [ACTION_W-1:0] ACT_CREATE        = 3'd0;
  localparam logic [ACTION_W-1:0] ACT_ADD_AFTER     = 3'd1;
  localparam logic [ACTION_W-1:0] ACT_INSERT_BEFORE = 3'd2;
  localparam logic [ACTION_W-1:0] ACT_APPEND        = 3'd3;
  localparam logic [ACTION_W-1:0] ACT_PREPEND       = 3'd4;
  localparam logic [ACTION_W-1:0] ACT_COUNT         = 3'd5;

  localparam logic [STATUS_W-1:0] ST_OK        = 2'd0;
  localparam logic [STATUS_W-1:0] ST_EXHAUSTED = 2'd1;
  localparam logic [STATUS_W-1:0] ST_NO_LIST   = 2'd2;

  typedef struct packed {
    logic [ACTION_W-1:0]  action;
    logic [LIST_ID_W-1:0] list_id;
    logic [ITEM_W-1:0]    item;
  } pdll_req_t;

  typedef struct packed {
    logic [STATUS_W-1:0]  status;
    logic [LIST_ID_W-1:0] list_id_res;
    logic [COUNT_W-1:0]   count;
  } pdll_rsp_t;

  typedef struct packed {
    logic load;
    logic eval;
    logic link;
    logic fixup;
    logic emit;
  } pdll_cmd_t;

  typedef struct packed {
    logic insert_ok;
    logic out_free;
  } pdll_sts_t;

endpackage

// ----- design/pdll_stream_if.sv -----
// Valid/ready stream interface carrying one payload per transaction.
interface pdll_stream_if #(
  parameter type payload_t = logic
);
  logic     valid;
  logic     ready;
  payload_t data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

// ----- design/pooled_doubly_linked_list_core.sv -----
// Count, create and error requests go through EVAL and then DONE; insertions add LINK
// and FIXUP after EVAL (cursor link read, new node write, neighbour write).
// One request is handled at a time, bounded by the single-port node link memories;
// a new request is taken as the result is registered, once the output slot is free.
// Reset: asynchronous; lists empty, counters zero, node memories not cleared.
module pooled_doubly_linked_list_core #(
  parameter int MAX_LISTS = 8,
  parameter int MAX_NODES = 256,
  parameter int ITEM_BITS = 32
) (
  input logic          clk_i,
  input logic          rst_ni,
  pdll_stream_if.sink   in_i,
  pdll_stream_if.source out_o
);
  import pdll_pkg::*;

  pdll_cmd_t cmd;
  pdll_sts_t sts;
  pdll_req_t req;
  pdll_rsp_t rsp;
  logic      in_ready;
  logic      out_valid;

  assign req         = in_i.data;
  assign in_i.ready  = in_ready;
  assign out_o.valid = out_valid;
  assign out_o.data  = rsp;

  pdll_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_i.valid),
    .in_ready_o (in_ready),
    .sts_i      (sts),
    .cmd_o      (cmd)
  );

  pdll_datapath #(
    .MAX_LISTS (MAX_LISTS),
    .MAX_NODES (MAX_NODES),
    .ITEM_BITS (ITEM_BITS)
  ) u_datapath (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .req_i       (req),
    .cmd_i       (cmd),
    .sts_o       (sts),
    .out_valid_o (out_valid),
    .out_ready_i (out_o.ready),
    .out_data_o  (rsp)
  );

endmodule

// ----- design/pdll_ctrl.sv -----
// Request sequencer for the pooled doubly linked list block.
module pdll_ctrl (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 in_valid_i,
  output logic                 in_ready_o,
  input  pdll_pkg::pdll_sts_t  sts_i,
  output pdll_pkg::pdll_cmd_t  cmd_o
);
  import pdll_pkg::*;

  typedef enum logic [2:0] {
    S_IDLE,
    S_EVAL,
    S_LINK,
    S_FIXUP,
    S_DONE
  } state_e;

  state_e state_q, state_d;

  always_comb begin
    state_d    = state_q;
    cmd_o      = '0;
    in_ready_o = 1'b0;
    case (state_q)
      S_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          cmd_o.load = 1'b1;
          state_d    = S_EVAL;
        end
      end
      S_EVAL: begin
        cmd_o.eval = 1'b1;
        state_d    = sts_i.insert_ok ? S_LINK : S_DONE;
      end
      S_LINK: begin
        cmd_o.link = 1'b1;
        state_d    = S_FIXUP;
      end
      S_FIXUP: begin
        cmd_o.fixup = 1'b1;
        state_d     = S_DONE;
      end
      S_DONE: begin
        if (sts_i.out_free) begin
          cmd_o.emit = 1'b1;
          in_ready_o = 1'b1;
          cmd_o.load = in_valid_i;
          state_d    = in_valid_i ? S_EVAL : S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

endmodule

// ----- design/pdll_datapath.sv -----
// List table, node link memories and result register.
module pdll_datapath #(
  parameter int MAX_LISTS = 8,
  parameter int MAX_NODES = 256,
  parameter int ITEM_BITS = 32
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  pdll_pkg::pdll_req_t  req_i,
  input  pdll_pkg::pdll_cmd_t  cmd_i,
  output pdll_pkg::pdll_sts_t  sts_o,
  output logic                 out_valid_o,
  input  logic                 out_ready_i,
  output pdll_pkg::pdll_rsp_t  out_data_o
);
  import pdll_pkg::*;

  localparam int NODE_W = $clog2(MAX_NODES + 1);
  localparam int ADDR_W = $clog2(MAX_NODES);
  localparam int LIST_W = (MAX_LISTS > 1) ? $clog2(MAX_LISTS) : 1;
  localparam int LCNT_W = $clog2(MAX_LISTS + 1);
  localparam logic [NODE_W-1:0] NIL        = NODE_W'(MAX_NODES);
  localparam logic [LCNT_W-1:0] LISTS_FULL = LCNT_W'(MAX_LISTS);

  function automatic logic is_node(input logic [NODE_W-1:0] x);
    return x < NIL;
  endfunction

  // request
  logic [ACTION_W-1:0]  act_q;
  logic [LIST_ID_W-1:0] lid_q;
  logic [ITEM_BITS-1:0] item_q;

  // list table
  logic [NODE_W-1:0] head_q [MAX_LISTS];
  logic [NODE_W-1:0] tail_q [MAX_LISTS];
  logic [NODE_W-1:0] cur_q  [MAX_LISTS];
  logic [NODE_W-1:0] size_q [MAX_LISTS];
  logic [LCNT_W-1:0] lists_made_q;
  logic [NODE_W-1:0] nodes_used_q;

  // node store
  logic [NODE_W-1:0]    next_mem [MAX_NODES];
  logic [NODE_W-1:0]    prev_mem [MAX_NODES];
  logic [ITEM_BITS-1:0] item_mem [MAX_NODES];
  logic [NODE_W-1:0]    rd_next_q, rd_prev_q;

  // result and neighbour fix-up
  logic [STATUS_W-1:0]  res_status_q;
  logic [LIST_ID_W-1:0] res_id_q;
  logic                 res_cnt_sel_q;
  logic                 fix_next_en_q, fix_prev_en_q;
  logic [ADDR_W-1:0]    fix_next_addr_q, fix_prev_addr_q;
  logic [NODE_W-1:0]    new_n_q;
  logic                 out_valid_q;
  pdll_rsp_t            out_data_q;

  logic [LIST_W-1:0] lidx, new_lidx;
  logic [NODE_W-1:0] l_head, l_tail, l_cur, l_size;
  logic              known, is_ins, full, create_ok, insert_ok;
  logic [ADDR_W-1:0] n_addr, cur_addr;

  assign lidx      = LIST_W'(lid_q);
  assign new_lidx  = LIST_W'(lists_made_q);
  assign l_head    = head_q[lidx];
  assign l_tail    = tail_q[lidx];
  assign l_cur     = cur_q[lidx];
  assign l_size    = size_q[lidx];
  assign known     = (32'(lid_q) < 32'(lists_made_q)) && (32'(lid_q) < MAX_LISTS);
  assign is_ins    = (act_q == ACT_ADD_AFTER) || (act_q == ACT_INSERT_BEFORE) ||
                     (act_q == ACT_APPEND) || (act_q == ACT_PREPEND);
  assign full      = (nodes_used_q == NIL);
  assign create_ok = (lists_made_q != LISTS_FULL);
  assign insert_ok = (act_q != ACT_CREATE) && known && is_ins && !full;
  assign n_addr    = ADDR_W'(nodes_used_q);
  assign cur_addr  = ADDR_W'(l_cur);

  // link computation for the new node
  logic              empty_like;
  logic [NODE_W-1:0] lk_next, lk_prev;
  logic              lk_head_upd, lk_tail_upd;
  logic              lk_fn_en, lk_fp_en;
  logic [ADDR_W-1:0] lk_fn_addr, lk_fp_addr;

  always_comb begin
    empty_like  = (l_size == '0) ||
                  (!is_node(l_cur) &&
                   ((act_q == ACT_ADD_AFTER) || (act_q == ACT_INSERT_BEFORE)));
    lk_next     = NIL;
    lk_prev     = NIL;
    lk_head_upd = 1'b0;
    lk_tail_upd = 1'b0;
    lk_fn_en    = 1'b0;
    lk_fp_en    = 1'b0;
    lk_fn_addr  = '0;
    lk_fp_addr  = '0;
    if (empty_like) begin
      lk_head_upd = 1'b1;
      lk_tail_upd = 1'b1;
    end else begin
      case (act_q)
        ACT_ADD_AFTER: begin
          lk_prev     = l_cur;
          lk_next     = rd_next_q;
          lk_fp_en    = is_node(rd_next_q);
          lk_fp_addr  = ADDR_W'(rd_next_q);
          lk_tail_upd = !is_node(rd_next_q);
          lk_fn_en    = 1'b1;
          lk_fn_addr  = cur_addr;
        end
        ACT_INSERT_BEFORE: begin
          lk_next     = l_cur;
          lk_prev     = rd_prev_q;
          lk_fn_en    = is_node(rd_prev_q);
          lk_fn_addr  = ADDR_W'(rd_prev_q);
          lk_head_upd = !is_node(rd_prev_q);
          lk_fp_en    = 1'b1;
          lk_fp_addr  = cur_addr;
        end
        ACT_APPEND: begin
          lk_prev     = l_tail;
          lk_fn_en    = is_node(l_tail);
          lk_fn_addr  = ADDR_W'(l_tail);
          lk_tail_upd = 1'b1;
        end
        default: begin
          lk_next     = l_head;
          lk_fp_en    = is_node(l_head);
          lk_fp_addr  = ADDR_W'(l_head);
          lk_head_upd = 1'b1;
        end
      endcase
    end
  end

  // node store write port selection
  logic              next_we, prev_we;
  logic [ADDR_W-1:0] next_wa, prev_wa;
  logic [NODE_W-1:0] next_wd, prev_wd;

  always_comb begin
    next_we = cmd_i.link || (cmd_i.fixup && fix_next_en_q);
    prev_we = cmd_i.link || (cmd_i.fixup && fix_prev_en_q);
    next_wa = cmd_i.link ? n_addr : fix_next_addr_q;
    prev_wa = cmd_i.link ? n_addr : fix_prev_addr_q;
    next_wd = cmd_i.link ? lk_next : new_n_q;
    prev_wd = cmd_i.link ? lk_prev : new_n_q;
  end

  always_ff @(posedge clk_i) begin
    if (next_we) begin
      next_mem[next_wa] <= next_wd;
    end
    if (prev_we) begin
      prev_mem[prev_wa] <= prev_wd;
    end
    if (cmd_i.link) begin
      item_mem[n_addr] <= item_q;
    end
    if (cmd_i.eval && is_node(l_cur)) begin
      rd_next_q <= next_mem[cur_addr];
      rd_prev_q <= prev_mem[cur_addr];
    end
  end

  // request, result and fix-up registers
  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      act_q  <= req_i.action;
      lid_q  <= req_i.list_id;
      item_q <= ITEM_BITS'(req_i.item);
    end
    if (cmd_i.eval) begin
      res_id_q      <= lid_q;
      res_cnt_sel_q <= 1'b0;
      if (act_q == ACT_CREATE) begin
        res_status_q <= create_ok ? ST_OK : ST_EXHAUSTED;
        res_id_q     <= create_ok ? LIST_ID_W'(lists_made_q) : '0;
      end else if (!known) begin
        res_status_q <= ST_NO_LIST;
      end else begin
        res_status_q  <= (is_ins && full) ? ST_EXHAUSTED : ST_OK;
        res_cnt_sel_q <= 1'b1;
      end
    end
    if (cmd_i.link) begin
      fix_next_en_q   <= lk_fn_en;
      fix_prev_en_q   <= lk_fp_en;
      fix_next_addr_q <= lk_fn_addr;
      fix_prev_addr_q <= lk_fp_addr;
      new_n_q         <= nodes_used_q;
    end
    if (cmd_i.emit) begin
      out_data_q.status      <= res_status_q;
      out_data_q.list_id_res <= res_id_q;
      out_data_q.count       <= res_cnt_sel_q ? COUNT_W'(l_size) : '0;
    end
  end

  // list table and pool counters
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < MAX_LISTS; i++) begin
        head_q[i] <= NIL;
        tail_q[i] <= NIL;
        cur_q[i]  <= NIL;
        size_q[i] <= '0;
      end
      lists_made_q <= '0;
      nodes_used_q <= '0;
      out_valid_q  <= 1'b0;
    end else begin
      if (cmd_i.eval && (act_q == ACT_CREATE) && create_ok) begin
        head_q[new_lidx] <= NIL;
        tail_q[new_lidx] <= NIL;
        cur_q[new_lidx]  <= NIL;
        size_q[new_lidx] <= '0;
        lists_made_q     <= lists_made_q + LCNT_W'(1);
      end
      if (cmd_i.link) begin
        cur_q[lidx]  <= nodes_used_q;
        size_q[lidx] <= l_size + NODE_W'(1);
        if (lk_head_upd) begin
          head_q[lidx] <= nodes_used_q;
        end
        if (lk_tail_upd) begin
          tail_q[lidx] <= nodes_used_q;
        end
        nodes_used_q <= nodes_used_q + NODE_W'(1);
      end
      if (cmd_i.emit) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  assign sts_o.insert_ok = insert_ok;
  assign sts_o.out_free  = !out_valid_q || out_ready_i;
  assign out_valid_o     = out_valid_q;
  assign out_data_o      = out_data_q;

  a_link_has_node: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.link |-> (nodes_used_q < NIL))
    else $error("node taken from an exhausted pool");

  a_fixup_after_link: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.fixup |-> $past(cmd_i.link))
    else $error("neighbour fix-up without a preceding link");

  a_emit_slot_free: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.emit |-> (!out_valid_q || out_ready_i))
    else $error("result overwrites a pending transaction");

  a_lists_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    lists_made_q <= LISTS_FULL)
    else $error("list count beyond pool size");

endmodule

// ----- bench/testbench.sv -----
// Self-checking testbench for the pooled doubly linked list core: directed and random requests.
`timescale 1ns / 100ps

module testbench;
  import pdll_pkg::*;

  localparam int LIST_SLOTS = 8;
  localparam int POOL_NODES = 256;
  localparam int ITEM_BITS  = 32;
  localparam int RANDOM_REQS = 1550;
  localparam int SQUEEZE_AT = 600;
  localparam int SQUEEZE_CYCLES = 400;

  // codes 6 and 7 are undefined and read as a count
  localparam logic [ACTION_W-1:0] ACT_SPARE_LO = 3'd6;
  localparam logic [ACTION_W-1:0] ACT_SPARE_HI = 3'd7;

  logic clk_i;
  logic rst_ni;

  pdll_stream_if #(.payload_t(pdll_req_t)) req_if ();
  pdll_stream_if #(.payload_t(pdll_rsp_t)) rsp_if ();

  pooled_doubly_linked_list_core #(
    .MAX_LISTS(LIST_SLOTS),
    .MAX_NODES(POOL_NODES),
    .ITEM_BITS(ITEM_BITS)
  ) DUT (
    .clk_i (clk_i),
    .rst_ni(rst_ni),
    .in_i  (req_if),
    .out_o (rsp_if)
  );

  pdll_req_t pending_req[$];
  pdll_rsp_t expected_rsp[$];

  // mirrored list bookkeeping
  int list_len[LIST_SLOTS];
  int lists_open;
  int nodes_taken;

  int mismatches;
  int results_seen;
  int send_hold;
  int send_calm;
  int recv_hold;
  int recv_calm;
  bit squeezed;

  initial begin
    clk_i = 1'b0;
  end

  always #10 clk_i = ~clk_i;

  function automatic bit is_insertion(logic [ACTION_W-1:0] act);
    return act == ACT_ADD_AFTER || act == ACT_INSERT_BEFORE ||
           act == ACT_APPEND || act == ACT_PREPEND;
  endfunction

  function automatic pdll_rsp_t apply_request(pdll_req_t req);
    pdll_rsp_t rsp;
    rsp.status      = ST_OK;
    rsp.list_id_res = req.list_id;
    rsp.count       = '0;
    if (req.action == ACT_CREATE) begin
      if (lists_open < LIST_SLOTS) begin
        rsp.list_id_res    = LIST_ID_W'(lists_open);
        list_len[lists_open] = 0;
        lists_open++;
      end else begin
        rsp.status      = ST_EXHAUSTED;
        rsp.list_id_res = '0;
      end
    end else if (int'(req.list_id) >= lists_open) begin
      rsp.status = ST_NO_LIST;
    end else begin
      if (is_insertion(req.action)) begin
        if (nodes_taken >= POOL_NODES) begin
          rsp.status = ST_EXHAUSTED;
        end else begin
          nodes_taken++;
          list_len[req.list_id]++;
        end
      end
      rsp.count = COUNT_W'(list_len[req.list_id]);
    end
    return rsp;
  endfunction

  function automatic int pick_pause();
    int r;
    r = $urandom_range(0, 99);
    if (r < 60) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(4, 30);
  endfunction

  task automatic report_mismatch(string field, int got, int want);
    $display("mismatch on %s in result %0d: got %0d, want %0d", field, results_seen, got, want);
    mismatches++;
  endtask

  task automatic queue_req(logic [ACTION_W-1:0] act, logic [LIST_ID_W-1:0] id,
                           logic [ITEM_W-1:0] item);
    pdll_req_t req;
    req.action  = act;
    req.list_id = id;
    req.item    = item;
    pending_req.push_back(req);
  endtask

  // driver
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      req_if.valid <= 1'b0;
      req_if.data  <= '0;
      send_hold = 0;
      send_calm = 0;
    end else begin
      if (req_if.valid && req_if.ready)
        expected_rsp.push_back(apply_request(req_if.data));
      if (!req_if.valid || req_if.ready) begin
        if (send_hold > 0 || pending_req.size() == 0) begin
          if (send_hold > 0) send_hold--;
          req_if.valid <= 1'b0;
        end else begin
          req_if.valid <= 1'b1;
          req_if.data  <= pending_req.pop_front();
          if (send_calm > 0) begin
            send_calm--;
            send_hold = 0;
          end else begin
            send_hold = pick_pause();
            if ($urandom_range(0, 39) == 0) send_calm = $urandom_range(20, 80);
          end
        end
      end
    end
  end

  // monitor, also drives the result back-pressure
  always @(posedge clk_i or negedge rst_ni) begin
    pdll_rsp_t want;
    if (!rst_ni) begin
      rsp_if.ready <= 1'b0;
      recv_hold = 0;
      recv_calm = 0;
      squeezed  = 1'b0;
    end else begin
      if (rsp_if.valid && rsp_if.ready) begin
        if (expected_rsp.size() == 0) begin
          $display("unexpected result transaction: status %0d list %0d count %0d",
                   rsp_if.data.status, rsp_if.data.list_id_res, rsp_if.data.count);
          mismatches++;
        end else begin
          want = expected_rsp.pop_front();
          if (rsp_if.data.status !== want.status)
            report_mismatch("status", rsp_if.data.status, want.status);
          if (rsp_if.data.list_id_res !== want.list_id_res)
            report_mismatch("list_id_res", rsp_if.data.list_id_res, want.list_id_res);
          if (rsp_if.data.count !== want.count)
            report_mismatch("count", rsp_if.data.count, want.count);
        end
        results_seen++;
      end
      if (!squeezed && results_seen >= SQUEEZE_AT) begin
        squeezed  = 1'b1;
        recv_hold = SQUEEZE_CYCLES;
      end
      if (recv_hold > 0) begin
        recv_hold--;
        rsp_if.ready <= 1'b0;
      end else if (recv_calm > 0) begin
        recv_calm--;
        rsp_if.ready <= 1'b1;
      end else begin
        if ($urandom_range(0, 3) == 0) recv_hold = pick_pause();
        if ($urandom_range(0, 49) == 0) recv_calm = $urandom_range(20, 80);
        if (recv_hold > 0) begin
          recv_hold--;
          rsp_if.ready <= 1'b0;
        end else begin
          rsp_if.ready <= 1'b1;
        end
      end
    end
  end

  initial begin
    int r;
    int made;
    int total_reqs;
    logic [ACTION_W-1:0] act;
    logic [LIST_ID_W-1:0] id;
    rst_ni       = 1'b0;
    req_if.valid = 1'b0;
    req_if.data  = '0;
    rsp_if.ready = 1'b0;
    mismatches   = 0;
    results_seen = 0;
    lists_open   = 0;
    nodes_taken  = 0;
    foreach (list_len[i]) list_len[i] = 0;

    // requests to lists that do not exist yet
    queue_req(ACT_COUNT, 3'd0, '0);
    queue_req(ACT_ADD_AFTER, 3'd7, 32'hFFFF_FFFF);
    queue_req(ACT_SPARE_LO, 3'd2, '0);
    // list 0: every insertion kind, starting empty
    queue_req(ACT_CREATE, 3'd5, '0);
    queue_req(ACT_COUNT, 3'd0, '0);
    queue_req(ACT_ADD_AFTER, 3'd0, 32'h0000_0000);
    queue_req(ACT_INSERT_BEFORE, 3'd0, 32'hFFFF_FFFF);
    queue_req(ACT_INSERT_BEFORE, 3'd0, 32'h5555_5555);
    queue_req(ACT_APPEND, 3'd0, 32'hAAAA_AAAA);
    queue_req(ACT_PREPEND, 3'd0, 32'h8000_0001);
    queue_req(ACT_ADD_AFTER, 3'd0, 32'h7FFF_FFFE);
    queue_req(ACT_SPARE_HI, 3'd0, 32'hFFFF_FFFF);
    // lists 1 and 2 start with insert-before and append on an empty list
    queue_req(ACT_CREATE, 3'd7, 32'hFFFF_FFFF);
    queue_req(ACT_INSERT_BEFORE, 3'd1, 32'h1234_5678);
    queue_req(ACT_CREATE, 3'd0, '0);
    queue_req(ACT_APPEND, 3'd2, 32'hDEAD_BEEF);
    queue_req(ACT_PREPEND, 3'd1, 32'hCAFE_F00D);
    queue_req(ACT_PREPEND, 3'd2, 32'h0F0F_0F0F);
    queue_req(ACT_COUNT, 3'd1, '0);
    queue_req(ACT_SPARE_LO, 3'd1, '0);
    queue_req(ACT_APPEND, 3'd3, 32'hFFFF_FFFF);
    queue_req(ACT_COUNT, 3'd7, '0);

    made = 3;
    repeat (RANDOM_REQS) begin
      r = $urandom_range(0, 99);
      if (r < 5)
        act = ACT_CREATE;
      else if (r < 65)
        act = ACTION_W'($urandom_range(ACT_ADD_AFTER, ACT_PREPEND));
      else if (r < 90)
        act = ACT_COUNT;
      else
        act = ACTION_W'($urandom_range(ACT_SPARE_LO, ACT_SPARE_HI));
      if ($urandom_range(0, 9) < 8)
        id = LIST_ID_W'($urandom_range(0, made - 1));
      else
        id = LIST_ID_W'($urandom_range(0, LIST_SLOTS - 1));
      if (act == ACT_CREATE && made < LIST_SLOTS) made++;
      queue_req(act, id, $urandom);
    end
    total_reqs = pending_req.size();

    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;

    while (results_seen < total_reqs) @(posedge clk_i);
    repeat (12) @(posedge clk_i);

    if (mismatches == 0)
      $display("SUCCESS");
    else
      $display("FAILURE");
    $finish;
  end

  initial begin
    #10000000;
    $display("FAILURE");
    $finish;
  end

endmodule
